FILE: hdl/pud_pkg.sv
`timescale 1ns / 1ps

package pud_pkg;

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] HEX_BAD   = 8'hF0;

  localparam int MAX_RES = 4;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_STRICT       = 2'd0;
  localparam reg_idx_t REG_ALLOW_UNSAFE = 2'd1;
  localparam reg_idx_t REG_PLUS         = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_PAIR = 3'b100
  } phase_t;

  typedef struct packed {
    logic strict_mode;
    logic allow_unsafe;
    logic plus_as_space;
  } cfg_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       err;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] item;
    logic [2:0]         cnt;
  } res_list_t;

  function automatic logic is_safe(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h41 && b <= 8'h5A) || b == CH_DOT || b == CH_TILDE ||
           b == CH_DASH || b == CH_USCORE;
  endfunction

  function automatic logic [7:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else begin
      v = HEX_BAD;
    end
    return v;
  endfunction

  function automatic logic [7:0] raw_res(input logic [7:0] b, input logic plus);
    return (b == CH_PLUS && plus) ? CH_SPACE : b;
  endfunction

  function automatic logic raw_unsafe(input logic [7:0] b, input logic plus);
    return !(b == CH_PLUS && plus) && !is_safe(b);
  endfunction

  function automatic res_list_t push(input res_list_t l, input logic [7:0] b,
                                     input logic last, input logic err);
    res_list_t r;
    r = l;
    if (r.cnt < 3'(MAX_RES)) begin
      r.item[r.cnt[1:0]] = '{b: b, last: last, err: err};
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

FILE: hdl/pud_in_if.sv
`timescale 1ns / 1ps

interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: hdl/pud_out_if.sv
`timescale 1ns / 1ps

interface pud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;
  modport source (output valid, output out_byte, output out_last, output out_error,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_error,
                  output ready);
endinterface

FILE: hdl/pud_cfg_if.sv
`timescale 1ns / 1ps

interface pud_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/url_percent_decoder.sv
`timescale 1ns / 1ps
// channel  role          word
// -------  ------------  ------------------------------------
// cfg      config write  index (2b), data (1b)
// enc      encoded in    in_byte, in_last
// dec      decoded out   out_byte, out_last, out_error
//
// One word is decoded on acceptance; its 0 to 4 results are loaded into a
// result buffer and leave one per cycle while dec is ready. enc is held off
// while the buffer drains, until it is down to its last result and dec is
// ready. Synchronous reset clears the decoder state and the buffer and sets
// all three registers. A dec stall holds enc off while the buffer holds any
// result.

module url_percent_decoder import pud_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pud_cfg_if.sink    cfg,
  pud_in_if.sink     enc,
  pud_out_if.source  dec
);

  cfg_t      regs;
  res_list_t list;
  logic      room;
  logic      accept;

  assign enc.ready = room;
  assign accept    = enc.valid && room;

  pud_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pud_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .accept  (accept),
    .in_byte (enc.in_byte),
    .in_last (enc.in_last),
    .list    (list)
  );

  pud_res_buf u_buf (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .list (list),
    .room (room),
    .dec  (dec)
  );

endmodule

FILE: hdl/pud_cfg_regs.sv
`timescale 1ns / 1ps

module pud_cfg_regs import pud_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pud_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{strict_mode: 1'b1, allow_unsafe: 1'b1, plus_as_space: 1'b1};
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_STRICT:       regs.strict_mode   <= cfg.data;
        REG_ALLOW_UNSAFE: regs.allow_unsafe  <= cfg.data;
        REG_PLUS:         regs.plus_as_space <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/pud_decode.sv
`timescale 1ns / 1ps

module pud_decode import pud_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output res_list_t  list
);

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  logic       dropping, dropping_next;
  logic       saw_unsafe, saw_unsafe_next;

  always_comb begin
    res_list_t  l;
    phase_t     ph;
    logic [7:0] hd;
    logic       saw;
    logic       drop;
    logic       done;
    logic [7:0] dv;
    logic [7:0] ev;
    l    = '0;
    ph   = phase;
    hd   = held;
    saw  = saw_unsafe;
    drop = dropping;
    done = 1'b0;
    dv   = hex_val(held);
    ev   = hex_val(in_byte);

    if (dropping) begin
      if (in_last) drop = 1'b0;
      done = 1'b1;
    end else if (ph == PH_PAIR) begin
      if (((dv | ev) & HEX_BAD) != 8'h00) begin
        if (regs.strict_mode) begin
          l    = push(l, 8'h00, 1'b1, 1'b1);
          ph   = PH_IDLE;
          hd   = 8'h00;
          saw  = 1'b0;
          drop = !in_last;
          done = 1'b1;
        end else begin
          // lenient: literal '%', then held byte and this byte decoded afresh
          ph = PH_IDLE;
          l  = push(l, CH_PCT, 1'b0, 1'b0);
          if (hd == CH_PCT) begin
            ph = PH_PCT;
          end else begin
            l   = push(l, raw_res(hd, regs.plus_as_space), 1'b0, 1'b0);
            saw = saw | raw_unsafe(hd, regs.plus_as_space);
          end
          if (ph == PH_IDLE) begin
            if (in_byte == CH_PCT) begin
              ph = PH_PCT;
            end else begin
              l   = push(l, raw_res(in_byte, regs.plus_as_space), 1'b0, 1'b0);
              saw = saw | raw_unsafe(in_byte, regs.plus_as_space);
            end
          end else begin
            hd = in_byte;
            ph = PH_PAIR;
          end
        end
      end else begin
        l  = push(l, {dv[3:0], ev[3:0]}, 1'b0, 1'b0);
        ph = PH_IDLE;
        hd = 8'h00;
      end
    end else if (ph == PH_IDLE) begin
      if (in_byte == CH_PCT) begin
        ph = PH_PCT;
      end else begin
        l   = push(l, raw_res(in_byte, regs.plus_as_space), 1'b0, 1'b0);
        saw = saw | raw_unsafe(in_byte, regs.plus_as_space);
      end
    end else begin
      hd = in_byte;
      ph = PH_PAIR;
    end

    if (!done && in_last) begin
      if (ph != PH_IDLE) begin
        if (regs.strict_mode) begin
          l    = push(l, 8'h00, 1'b1, 1'b1);
          drop = 1'b0;
          done = 1'b1;
        end else begin
          l = push(l, CH_PCT, 1'b0, 1'b0);
          if (ph == PH_PAIR) begin
            if (hd == CH_PCT) begin
              l = push(l, CH_PCT, 1'b0, 1'b0);
            end else begin
              l   = push(l, raw_res(hd, regs.plus_as_space), 1'b0, 1'b0);
              saw = saw | raw_unsafe(hd, regs.plus_as_space);
            end
          end
        end
      end
      if (!done) begin
        if (!regs.allow_unsafe && saw) begin
          l = push(l, 8'h00, 1'b1, 1'b1);
        end else if (l.cnt != 3'd0) begin
          l.item[l.cnt[1:0] - 2'd1].last = 1'b1;
        end
      end
      ph  = PH_IDLE;
      hd  = 8'h00;
      saw = 1'b0;
    end

    list            = l;
    phase_next      = ph;
    held_next       = hd;
    saw_unsafe_next = saw;
    dropping_next   = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held       <= 8'h00;
      dropping   <= 1'b0;
      saw_unsafe <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      held       <= held_next;
      dropping   <= dropping_next;
      saw_unsafe <= saw_unsafe_next;
    end
  end

endmodule

FILE: hdl/pud_res_buf.sv
`timescale 1ns / 1ps

module pud_res_buf import pud_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_list_t  list,
  output logic       room,
  pud_out_if.source  dec
);

  res_t [MAX_RES-1:0] items;
  logic [2:0]         left;
  logic [1:0]         rd;
  logic               take;

  assign take      = dec.valid && dec.ready;
  assign room      = (left == 3'd0) || (left == 3'd1 && dec.ready);
  assign dec.valid = (left != 3'd0);
  assign dec.out_byte  = items[rd].b;
  assign dec.out_last  = items[rd].last;
  assign dec.out_error = items[rd].err;

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
      rd   <= 2'd0;
    end else if (load) begin
      left <= list.cnt;
      rd   <= 2'd0;
    end else if (take) begin
      left <= left - 3'd1;
      rd   <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items <= list.item;
    end
  end

endmodule

FILE: test/tb_url_percent_decoder.sv
`timescale 1ns / 1ps

module tb_url_percent_decoder import pud_pkg::*;;

  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN       = 4;
  localparam int WATCHDOG    = 3000;
  localparam int N_PHASES    = 10;
  localparam int PHASE_WORDS = 35;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    reg_idx_t   idx;
    logic       val;
    logic [7:0] b;
    logic       l;
    logic       preset;
    res_t       want;
  } row_t;

  function automatic row_t wd(input logic [7:0] b, input logic l);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.b = b;
    r.l = l;
    return r;
  endfunction

  function automatic row_t wt(input logic [7:0] b, input logic l, input logic [7:0] rb,
                              input logic rl, input logic re);
    row_t r;
    r = wd(b, l);
    r.preset = 1'b1;
    r.want = '{b: rb, last: rl, err: re};
    return r;
  endfunction

  function automatic row_t cw(input reg_idx_t idx, input logic v);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = v;
    return r;
  endfunction

  localparam row_t DIRECTED [30] = '{
    wt(8'h41, 1'b1, 8'h41, 1'b1, 1'b0),
    wt(8'h00, 1'b1, 8'h00, 1'b1, 1'b0),
    wt(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0),
    wt(8'h2B, 1'b1, 8'h20, 1'b1, 1'b0),
    wd(8'h25, 1'b0), wd(8'h34, 1'b0), wd(8'h31, 1'b1),
    wd(8'h25, 1'b0), wd(8'h66, 1'b0), wd(8'h46, 1'b1),
    // strict: bad pair rejects, tail dropped
    wd(8'h25, 1'b0), wd(8'h47, 1'b0), wt(8'h31, 1'b0, 8'h00, 1'b1, 1'b1), wd(8'h78, 1'b1),
    wd(8'h25, 1'b0), wt(8'h34, 1'b1, 8'h00, 1'b1, 1'b1),
    cw(REG_STRICT, 1'b0),
    wd(8'h25, 1'b0), wd(8'h5A, 1'b0), wd(8'h71, 1'b1),
    wd(8'h25, 1'b0), wd(8'h25, 1'b1),
    cw(REG_ALLOW_UNSAFE, 1'b0), cw(REG_PLUS, 1'b0),
    wd(8'h2B, 1'b1),
    cw(REG_PLUS, 1'b1),
    // unsafe bytes allowed again (unsafe check off) mid message
    wd(8'h61, 1'b0), wd(8'h21, 1'b0), cw(REG_ALLOW_UNSAFE, 1'b1), wd(8'h25, 1'b1)
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pud_cfg_if cfg ();
  pud_in_if  enc ();
  pud_out_if dec ();

  url_percent_decoder DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .enc (enc),
    .dec (dec)
  );

  always #2 clk = ~clk;

  // decoder model state
  logic       cur_strict, cur_unsafe_ok, cur_plus;
  phase_t     esc;
  logic [7:0] held;
  logic       skipping;
  logic       saw_bad;
  res_t       pend [MAX_RES];
  int         pend_n;

  res_t       decoded_q [$];
  logic [7:0] msg_q [$];
  string      safe_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz.~-_";

  int   n_words, n_results, n_rejects, n_cfg, n_fail;
  logic idle_on;
  logic hold_req;
  res_t seen, due;

  function automatic logic url_safe(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CH_DOT || b == CH_TILDE ||
           b == CH_DASH || b == CH_USCORE;
  endfunction

  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      return c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      return c - 8'h61 + 8'd10;
    end
    return HEX_BAD;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic up);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return (up ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic report(input string what);
    n_fail++;
    if (n_fail <= 50) begin
      $display("ERROR @%0t: %s", $realtime, what);
    end
  endtask

  task automatic put(input logic [7:0] b, input logic l, input logic e);
    if (pend_n < MAX_RES) begin
      pend[pend_n] = '{b: b, last: l, err: e};
      pend_n++;
    end
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (esc == PH_IDLE) begin
      if (b == CH_PCT) begin
        esc = PH_PCT;
      end else if (b == CH_PLUS && cur_plus) begin
        put(CH_SPACE, 1'b0, 1'b0);
      end else begin
        if (!url_safe(b)) saw_bad = 1'b1;
        put(b, 1'b0, 1'b0);
      end
    end else begin
      held = b;
      esc = PH_PAIR;
    end
  endtask

  task automatic clear_msg();
    esc = PH_IDLE;
    held = 8'h00;
    saw_bad = 1'b0;
  endtask

  task automatic reject_msg(input logic l);
    put(8'h00, 1'b1, 1'b1);
    clear_msg();
    skipping = !l;
  endtask

  task automatic decode_word(input logic [7:0] b, input logic l);
    logic [7:0] hi, lo;
    pend_n = 0;
    if (skipping) begin
      if (l) skipping = 1'b0;
      return;
    end
    if (esc == PH_PAIR) begin
      hi = nibble_of(held);
      lo = nibble_of(b);
      if (((hi | lo) & HEX_BAD) != 8'h00) begin
        if (cur_strict) begin
          reject_msg(l);
          return;
        end
        esc = PH_IDLE;
        put(CH_PCT, 1'b0, 1'b0);
        take_plain(held);
        take_plain(b);
      end else begin
        put({hi[3:0], lo[3:0]}, 1'b0, 1'b0);
        esc = PH_IDLE;
        held = 8'h00;
      end
    end else begin
      take_plain(b);
    end
    if (!l) return;
    if (esc != PH_IDLE) begin
      if (cur_strict) begin
        reject_msg(1'b1);
        return;
      end
      put(CH_PCT, 1'b0, 1'b0);
      if (esc == PH_PAIR) begin
        esc = PH_IDLE;
        take_plain(held);
        if (esc == PH_PCT) put(CH_PCT, 1'b0, 1'b0);
      end
      esc = PH_IDLE;
    end
    if (!cur_unsafe_ok && saw_bad) begin
      put(8'h00, 1'b1, 1'b1);
    end else if (pend_n > 0) begin
      pend[pend_n-1].last = 1'b1;
    end
    clear_msg();
  endtask

  task automatic idle_enc(input int n);
    repeat (n) begin
      @(negedge clk);
      enc.valid <= 1'b0;
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic l, input logic preset,
                           input res_t want);
    int k;
    @(negedge clk);
    enc.valid   <= 1'b1;
    enc.in_byte <= b;
    enc.in_last <= l;
    do @(posedge clk); while (!enc.ready);
    n_words++;
    decode_word(b, l);
    if (preset) begin
      decoded_q.push_back(want);
    end else begin
      for (k = 0; k < pend_n; k++) decoded_q.push_back(pend[k]);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_STRICT:       cur_strict = v;
      REG_ALLOW_UNSAFE: cur_unsafe_ok = v;
      REG_PLUS:         cur_plus = v;
      default:          ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    idle_enc(1);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic gen_message();
    int         kind;
    logic [7:0] r;
    msg_q.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        msg_q.push_back(safe_chars[$urandom_range(0, safe_chars.len() - 1)]);
      end else if (kind < 60) begin
        msg_q.push_back(CH_PCT);
        msg_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        msg_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end else if (kind < 70) begin
        msg_q.push_back(CH_PLUS);
      end else if (kind < 80) begin
        do r = 8'($urandom_range(0, 255)); while (url_safe(r) || r == CH_PCT || r == CH_PLUS);
        msg_q.push_back(r);
      end else if (kind < 90) begin
        msg_q.push_back(CH_PCT);
        do r = 8'($urandom_range(0, 255)); while (nibble_of(r) != HEX_BAD);
        if ($urandom_range(0, 1)) begin
          msg_q.push_back(r);
          msg_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          msg_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          msg_q.push_back(r);
        end
      end else begin
        msg_q.push_back(CH_PCT);
        if ($urandom_range(0, 1)) begin
          msg_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
      end
    end
  endtask

  // output side back-pressure
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    dec.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        dec.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        dec.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        dec.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        dec.ready <= 1'b1;
      end else begin
        dec.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && dec.valid && dec.ready) begin
      seen = '{b: dec.out_byte, last: dec.out_last, err: dec.out_error};
      n_results++;
      if (seen.err) n_rejects++;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected word %02h last %0b err %0b", seen.b, seen.last, seen.err));
      end else begin
        due = decoded_q.pop_front();
        if (seen.b !== due.b || seen.last !== due.last || seen.err !== due.err) begin
          report($sformatf("word %0d: got %02h/%0b/%0b, want %02h/%0b/%0b", n_results,
                           seen.b, seen.last, seen.err, due.b, due.last, due.err));
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG) begin
      @(posedge clk);
      if (rst || (enc.valid && enc.ready) || (dec.valid && dec.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no progress for %0d cycles", WATCHDOG);
    $display("tb_url_percent_decoder: errors");
    $finish;
  end

  initial begin
    int   ph, start, k;
    logic s, u, p;
    enc.valid   = 1'b0;
    enc.in_byte = 8'h00;
    enc.in_last = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = REG_STRICT;
    cfg.data    = 1'b0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    n_words = 0; n_results = 0; n_rejects = 0; n_cfg = 0; n_fail = 0;
    cur_strict = 1'b1; cur_unsafe_ok = 1'b1; cur_plus = 1'b1;
    skipping = 1'b0;
    pend_n = 0;
    clear_msg();

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        settle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        if ($urandom_range(0, 3) == 0) idle_enc($urandom_range(1, 11));
        send_word(DIRECTED[i].b, DIRECTED[i].l, DIRECTED[i].preset, DIRECTED[i].want);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        s = 1'b1; u = 1'b1; p = 1'b1;
      end else if (ph == 1) begin
        s = 1'b0; u = 1'b0; p = 1'b0;
      end else begin
        s = 1'($urandom_range(0, 1));
        u = 1'($urandom_range(0, 1));
        p = 1'($urandom_range(0, 1));
      end
      write_reg(REG_STRICT, s);
      write_reg(REG_ALLOW_UNSAFE, u);
      write_reg(REG_PLUS, p);
      idle_on = !(ph == 4 || ph == N_PHASES - 1);
      if (ph == 2) hold_req = 1'b1;
      start = n_words;
      while (n_words - start < PHASE_WORDS) begin
        gen_message();
        for (k = 0; k < msg_q.size(); k++) begin
          if (idle_on && $urandom_range(0, 5) == 0) idle_enc($urandom_range(1, 11));
          send_word(msg_q[k], k == msg_q.size() - 1, 1'b0, '0);
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0) begin
      report($sformatf("%0d decoded words never arrived", decoded_q.size()));
    end

    $display("sent %0d encoded words and %0d register writes; %0d decoded words back, %0d rejects",
             n_words, n_cfg, n_results, n_rejects);
    $display("%0d register settings plus directed cases, one long output hold-off", N_PHASES);
    if (n_fail == 0) begin
      $display("tb_url_percent_decoder: clean");
    end else begin
      $display("tb_url_percent_decoder: errors");
    end
    $finish;
  end

endmodule
